>>> rtl/pracl_pkg.sv
// ---------------------------------------------------------------------------
// pracl_pkg: shared types and codes for the port range ACL table
// Transfer structs for both channels, item kinds, mode codes, status codes
// and register indexes.
// ---------------------------------------------------------------------------
package pracl_pkg;

   // Default number of rule slots
   localparam int RULE_SLOTS_DEF = 32;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Stored rule entry: valid, connect, tcp, hi, lo
   localparam int BODY_W  = 34;
   localparam int ENTRY_W = BODY_W + 1;

   // Item kinds
   localparam logic [1:0] KIND_CHECK  = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   // Per-direction modes
   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_PERMIT  = 2'd1;
   localparam logic [1:0] MODE_LEARN   = 2'd2;
   localparam logic [1:0] MODE_ENFORCE = 2'd3;

   // Check status codes
   localparam logic [2:0] CHK_UNCHECKED = 3'd0;
   localparam logic [2:0] CHK_TRUSTED   = 3'd1;
   localparam logic [2:0] CHK_MATCHED   = 3'd2;
   localparam logic [2:0] CHK_MISS_OK   = 3'd3;
   localparam logic [2:0] CHK_LEARNED   = 3'd4;
   localparam logic [2:0] CHK_DENIED    = 3'd5;

   // Update status codes
   localparam logic [2:0] UPD_DONE    = 3'd0;
   localparam logic [2:0] UPD_PRESENT = 3'd1;
   localparam logic [2:0] UPD_FULL    = 3'd2;
   localparam logic [2:0] UPD_ABSENT  = 3'd3;
   localparam logic [2:0] UPD_INVALID = 3'd4;

   // Register indexes
   localparam logic [1:0] REG_BIND_MODE    = 2'd0;
   localparam logic [1:0] REG_CONNECT_MODE = 2'd1;
   localparam logic [1:0] REG_TRUSTED      = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        is_connect_dir;
      logic        is_tcp;
      logic [15:0] port_low;
      logic [15:0] port_high;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       permitted;
      logic [4:0] slot_index;
   } rsp_type;

endpackage

>>> rtl/pracl_ram.sv
// ---------------------------------------------------------------------------
// pracl_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module pracl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/port_range_acl_table_unit.sv
// ---------------------------------------------------------------------------
// port_range_acl_table_unit: port range access control table
// Keeps bind/connect, TCP/UDP port range rules; adds, deletes and checks.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one transfer carries a check, add or delete item. The block
//   raises req_stall from acceptance until the result is loaded into the
//   output register, so one item is in work at a time.
//   rsp channel: one result per item, held in an output register until taken;
//   the next item may be accepted while that result waits.
//   csr port: APB writes of bind_mode (0x0), connect_mode (0x4) and
//   domain_trusted (0x8); write only while no item is in work.
// Scan: an item that needs the table is scanned one slot per cycle through
//   the single RAM read port and one compare unit, then goes to the
//   finishing step, which loads its result; the next item is taken once the
//   block is back in idle. Items answered without the table (mode off,
//   trusted, malformed) go from acceptance straight to the finishing step.
// Reset: control state and registers clear, then a clearing pass writes every
//   slot invalid with req_stall high.
// Receiver stall: the result holds in the output register; a finished item
//   waits in its last step until the register frees.
// ---------------------------------------------------------------------------
module port_range_acl_table_unit #(
   parameter int RULE_SLOTS = pracl_pkg::RULE_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pracl_pkg::req_type                  req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pracl_pkg::rsp_type                  rsp_data,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pracl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pracl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pracl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   import pracl_pkg::*;

   localparam int IDX_W = $clog2(RULE_SLOTS);
   localparam int CNT_W = $clog2(RULE_SLOTS + 1);
   localparam int EXT_W = (IDX_W > 5) ? IDX_W : 5;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   req_type           req_ff, req_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [1:0]        bind_mode_ff, connect_mode_ff;
   logic              trusted_ff;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   logic               req_xfer;
   logic               cnt_last;
   logic               eval_en;
   logic [IDX_W-1:0]   eval_idx;
   logic               ent_match;
   logic               fin_load;
   logic               fin_we;
   logic [IDX_W-1:0]   fin_waddr;
   logic [ENTRY_W-1:0] fin_wdata;
   logic [1:0]         fin_mode;
   logic [BODY_W-1:0]  req_key;
   logic [1:0]         csr_idx;
   logic               csr_wr;

   // Map a slot number onto the 5-bit result field
   function automatic logic [4:0] slot_field(input logic [IDX_W-1:0] idx);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(idx);
      return ext[4:0];
   endfunction

   // Rule table: valid bit plus body per slot
   pracl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RULE_SLOTS)
   ) u_rules (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_idx)
         REG_BIND_MODE:    csr_prdata = CSR_DATA_W'(bind_mode_ff);
         REG_CONNECT_MODE: csr_prdata = CSR_DATA_W'(connect_mode_ff);
         REG_TRUSTED:      csr_prdata = CSR_DATA_W'(trusted_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bind_mode_ff    <= MODE_OFF;
         connect_mode_ff <= MODE_OFF;
         trusted_ff      <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_BIND_MODE:    bind_mode_ff    <= csr_pwdata[1:0];
            REG_CONNECT_MODE: connect_mode_ff <= csr_pwdata[1:0];
            REG_TRUSTED:      trusted_ff      <= csr_pwdata[0];
            default:          ;
         endcase
      end
   end

   // Handshake on the request side
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // Scan counter and read address; data for slot cnt-1 arrives each cycle
   assign cnt_last  = (cnt_ff == CNT_W'(RULE_SLOTS));
   assign ram_raddr = cnt_last ? '0 : cnt_ff[IDX_W-1:0];
   assign eval_en   = (state_ff == ST_SCAN) && (cnt_ff != '0);
   assign eval_idx  = IDX_W'(cnt_ff - CNT_W'(1));
   assign req_key   = {req_ff.is_connect_dir, req_ff.is_tcp, req_ff.port_high,
                       req_ff.port_low};

   // Shared compare unit: cover test for checks, exact match for updates
   always_comb begin
      if (req_ff.kind == KIND_CHECK) begin
         ent_match = ram_rdata[BODY_W] &&
                     (ram_rdata[33:32] == {req_ff.is_connect_dir, req_ff.is_tcp}) &&
                     (ram_rdata[15:0] <= req_ff.port_low) &&
                     (req_ff.port_low <= ram_rdata[31:16]);
      end else begin
         ent_match = ram_rdata[BODY_W] && (ram_rdata[BODY_W-1:0] == req_key);
      end
   end

   // Decide the result once the scan is over
   assign fin_mode = req_ff.is_connect_dir ? connect_mode_ff : bind_mode_ff;
   assign fin_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in    = '0;
      fin_we    = 1'b0;
      fin_waddr = free_idx_ff;
      fin_wdata = {1'b1, req_key};
      case (req_ff.kind)
         KIND_CHECK: begin
            rsp_in.permitted = 1'b1;
            if (fin_mode == MODE_OFF) begin
               rsp_in.status = CHK_UNCHECKED;
            end else if (trusted_ff) begin
               rsp_in.status = CHK_TRUSTED;
            end else if (hit_ff) begin
               rsp_in.status     = CHK_MATCHED;
               rsp_in.slot_index = slot_field(hit_idx_ff);
            end else if (fin_mode == MODE_ENFORCE) begin
               rsp_in.status    = CHK_DENIED;
               rsp_in.permitted = 1'b0;
            end else if ((fin_mode == MODE_LEARN) && free_ff) begin
               rsp_in.status     = CHK_LEARNED;
               rsp_in.slot_index = slot_field(free_idx_ff);
               fin_we            = 1'b1;
               fin_wdata         = {1'b1, req_ff.is_connect_dir, req_ff.is_tcp,
                                    req_ff.port_low, req_ff.port_low};
            end else begin
               rsp_in.status = CHK_MISS_OK;
            end
         end
         KIND_ADD: begin
            if (req_ff.port_low > req_ff.port_high) begin
               rsp_in.status = UPD_INVALID;
            end else if (hit_ff) begin
               rsp_in.status     = UPD_PRESENT;
               rsp_in.permitted  = 1'b1;
               rsp_in.slot_index = slot_field(hit_idx_ff);
            end else if (free_ff) begin
               rsp_in.status     = UPD_DONE;
               rsp_in.permitted  = 1'b1;
               rsp_in.slot_index = slot_field(free_idx_ff);
               fin_we            = 1'b1;
            end else begin
               rsp_in.status = UPD_FULL;
            end
         end
         KIND_DELETE: begin
            if (req_ff.port_low > req_ff.port_high) begin
               rsp_in.status = UPD_INVALID;
            end else if (hit_ff) begin
               rsp_in.status     = UPD_DONE;
               rsp_in.permitted  = 1'b1;
               rsp_in.slot_index = slot_field(hit_idx_ff);
               fin_we            = 1'b1;
               fin_waddr         = hit_idx_ff;
               fin_wdata         = '0;
            end else begin
               rsp_in.status = UPD_ABSENT;
            end
         end
         default: begin
            rsp_in.status = UPD_INVALID;
         end
      endcase
   end

   // RAM write port: clearing pass or the finishing write
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = cnt_ff[IDX_W-1:0];
         ram_wdata = '0;
      end else begin
         ram_we    = fin_load && fin_we;
         ram_waddr = fin_waddr;
         ram_wdata = fin_wdata;
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_in      = req_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            // sweep every slot invalid
            if (cnt_ff == CNT_W'(RULE_SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               req_in  = req_data;
               hit_in  = 1'b0;
               free_in = 1'b0;
               cnt_in  = '0;
               // scan only when the answer depends on the table
               if (req_data.kind == KIND_CHECK) begin
                  if ((req_data.is_connect_dir ? connect_mode_ff : bind_mode_ff)
                        == MODE_OFF || trusted_ff) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (req_data.kind == KIND_ADD || req_data.kind == KIND_DELETE) begin
                  state_in = (req_data.port_low > req_data.port_high) ? ST_FINISH : ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            // record the lowest matching and the lowest free slot
            if (eval_en) begin
               if (ent_match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = eval_idx;
               end
               if (!ram_rdata[BODY_W] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = eval_idx;
               end
            end
            if (cnt_last) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (fin_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      if (fin_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (fin_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A denied or failed result never changes the table
   a_no_write_on_fail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && ram_we |-> rsp_in.permitted)
      else $error("table written for a failed item");

   // An accepted item goes straight to scanning or finishing
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SCAN) || (state_ff == ST_FINISH))
      else $error("accepted item not started");

   // Scanning ends only through the finishing step
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (state_ff == ST_SCAN) || (state_ff == ST_FINISH))
      else $error("scan left abnormally");

   // A new result appears only out of the finishing step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result without a finished item");

endmodule
